/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pctd_pkg.sv */
package pctd_pkg;

  localparam int VALUE_BITS      = 31;
  localparam int COUNT_OUT_BITS  = 16;
  localparam int DEF_VALUE_WIDTH = 31;
  localparam int DEF_COUNT_WIDTH = 16;

  typedef struct packed {
    logic capture;    // take the input word
    logic init_div;   // divisor back to 3
    logic start_div;  // preload remainder for current divisor
    logic step;       // one remainder bit
    logic emit;       // load output register
    logic prime;      // verdict that goes with emit
  } pctd_cmd_t;

  typedef struct packed {
    logic lt2;
    logic lt4;
    logic even;
    logic sq_gt;      // divisor squared exceeds value
    logic last_bit;   // current step finishes the remainder
    logic rem_zero;   // remainder after current step is zero
    logic out_busy;   // output register still waiting
  } pctd_status_t;

endpackage

/* src/pctd_in_if.sv */
interface pctd_in_if;
  logic                             valid;
  logic                             ready;
  logic [pctd_pkg::VALUE_BITS-1:0]  value;
  logic                             last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

/* src/pctd_out_if.sv */
interface pctd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 is_prime;
  logic [pctd_pkg::COUNT_OUT_BITS-1:0]  prime_count;
  logic                                 set_done;

  modport source (output valid, output is_prime, output prime_count, output set_done,
                  input ready);
  modport sink   (input valid, input is_prime, input prime_count, input set_done,
                  output ready);
endinterface

/* src/pctd_datapath.sv */
module pctd_datapath #(
  parameter int VALUE_WIDTH = pctd_pkg::DEF_VALUE_WIDTH,
  parameter int COUNT_WIDTH = pctd_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pctd_pkg::pctd_cmd_t                  cmd,
  output pctd_pkg::pctd_status_t               status,
  input  logic [pctd_pkg::VALUE_BITS-1:0]      in_value,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_is_prime,
  output logic [pctd_pkg::COUNT_OUT_BITS-1:0]  out_prime_count,
  output logic                                 out_set_done
);

  localparam int VW = VALUE_WIDTH;
  localparam int DW = VALUE_WIDTH / 2 + 2;   // divisor never passes sqrt(2^VW) + 2
  localparam int SW = VALUE_WIDTH + 1;       // divisor squared
  localparam int KW = $clog2(VALUE_WIDTH + 1);

  logic [VW-1:0]          val;
  logic                   last_q;
  logic [DW-1:0]          d;
  logic [SW-1:0]          sq;
  logic [KW-1:0]          k;       // floor(log2(d))
  logic [DW-1:0]          r;
  logic [KW-1:0]          idx;
  logic [COUNT_WIDTH-1:0] running;

  logic [DW:0]            r_shift;
  logic [DW:0]            r_sub;
  logic [DW-1:0]          r_new;
  logic [DW-1:0]          r_pre;
  logic [KW-1:0]          idx_init;
  logic [DW-1:0]          d_next;
  logic [SW-1:0]          sq_next;
  logic [KW-1:0]          k_inc;
  logic [KW-1:0]          k_next;
  logic [COUNT_WIDTH-1:0] cnt_inc;

  // one bit of restoring division per step
  assign r_shift = {r, val[idx]};
  assign r_sub   = r_shift - {1'b0, d};
  assign r_new   = (r_shift >= {1'b0, d}) ? r_sub[DW-1:0] : r_shift[DW-1:0];

  // top k bits of the value are already below the divisor
  assign r_pre    = DW'(val >> (KW'(VALUE_WIDTH) - k));
  assign idx_init = KW'(VALUE_WIDTH - 1) - k;

  // (d+2)^2 = d^2 + 4d + 4
  assign d_next  = d + DW'(2);
  assign sq_next = sq + SW'({d, 2'b00}) + SW'(4);
  assign k_inc   = k + KW'(1);
  assign k_next  = ((d_next >> k_inc) != '0) ? k_inc : k;

  assign cnt_inc = (cmd.prime && running != '1) ? running + COUNT_WIDTH'(1) : running;

  always_comb begin
    status.lt2      = val < VW'(2);
    status.lt4      = val < VW'(4);
    status.even     = !val[0];
    status.sq_gt    = sq > SW'(val);
    status.last_bit = idx == '0;
    status.rem_zero = r_new == '0;
    status.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val    <= in_value[VW-1:0];
      last_q <= in_last;
    end
    if (cmd.init_div) begin
      d  <= DW'(3);
      sq <= SW'(9);
      k  <= KW'(1);
    end
    if (cmd.start_div) begin
      r   <= r_pre;
      idx <= idx_init;
    end
    if (cmd.step) begin
      r   <= r_new;
      idx <= idx - KW'(1);
      if (idx == '0) begin
        d  <= d_next;
        sq <= sq_next;
        k  <= k_next;
      end
    end
    if (cmd.emit) begin
      out_is_prime    <= cmd.prime;
      out_prime_count <= pctd_pkg::COUNT_OUT_BITS'(cnt_inc);
      out_set_done    <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        running   <= last_q ? '0 : cnt_inc;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/pctd_ctrl.sv */
module pctd_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pctd_pkg::pctd_status_t  status,
  output pctd_pkg::pctd_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_CHECK,
    S_STEP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   verdict;
  logic   verdict_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next   = state;
    verdict_next = verdict;
    cmd          = '0;
    cmd.prime    = verdict;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (status.lt2) begin
          verdict_next = 1'b0;
          state_next   = S_DONE;
        end else if (status.lt4) begin
          verdict_next = 1'b1;
          state_next   = S_DONE;
        end else if (status.even) begin
          verdict_next = 1'b0;
          state_next   = S_DONE;
        end else begin
          cmd.init_div = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.sq_gt) begin
          verdict_next = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (status.last_bit) begin
          if (status.rem_zero) begin
            verdict_next = 1'b0;
            state_next   = S_DONE;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      verdict <= 1'b0;
    end else begin
      state   <= state_next;
      verdict <= verdict_next;
    end
  end

endmodule

/* src/prime_count_trial_division.sv */
// Primality tester and per-set prime counter.
// in_ch carries one word per item: value (low VALUE_WIDTH bits used) and last,
// which closes the current set. out_ch returns one word per item: is_prime,
// prime_count (primes so far in the set including this one, saturating at
// 2^COUNT_WIDTH-1, low 16 bits shown) and set_done (copy of last).
// One item is in work at a time; in_ch.ready is high only while idle.
// Values below 4 and even values are settled in S_CLASSIFY and go straight to S_DONE.
// Odd values are trial-divided by 3, 5, 7, ... while d*d <= value; each
// divisor runs S_CHECK and then S_STEP over the low VALUE_WIDTH - floor(log2(d))
// value bits in a bit-serial remainder unit. Worst case for 31-bit primes is
// about 23k divisors.
// The result sits in an output register; a new item is accepted and worked
// on while out_ch is stalled, and it only waits at the end for the register
// to free up.
// Synchronous reset clears the controller, the output valid and the running
// count; no warm-up is needed.
`include "assert_macros.svh"

module prime_count_trial_division #(
  parameter int VALUE_WIDTH = pctd_pkg::DEF_VALUE_WIDTH,
  parameter int COUNT_WIDTH = pctd_pkg::DEF_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  pctd_in_if.sink     in_ch,
  pctd_out_if.source  out_ch
);

  pctd_pkg::pctd_cmd_t    cmd;
  pctd_pkg::pctd_status_t status;

  pctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pctd_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_value        (in_ch.value),
    .in_last         (in_ch.last),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_is_prime    (out_ch.is_prime),
    .out_prime_count (out_ch.prime_count),
    .out_set_done    (out_ch.set_done)
  );

  `ASSERT_NXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready, "second word taken while busy")
  `ASSERT_IMP(a_no_overwrite, cmd.emit, !status.out_busy, "pending result overwritten")
  `ASSERT_IMP(a_prime_counted, out_ch.valid && out_ch.is_prime, (COUNT_WIDTH > 16) || (out_ch.prime_count != 0), "prime result with zero count")

endmodule
